// File: rtl/pfab_pkg.sv
// ----------------------------------------------------------------------------
// pfab_pkg: shared types and constants of the per-frame bump allocator
// Field widths, mode/status/register codes and the structs that travel
// between the config block, the remainder unit and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pfab_pkg;

    // payload field widths
    localparam int MODE_W     = 2;
    localparam int OFF_W      = 25;
    localparam int ALIGN_W    = 13;
    localparam int FRAME_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 4;
    localparam int COUNT_W    = 32;
    localparam int SCOUNT_W   = 5;

    // shared remainder unit
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 13;
    localparam int REM_CNT_W  = 5;

    // config port
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // item modes
    localparam logic [MODE_W-1:0] MODE_BEGIN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // register indexes (byte address bits 3:2)
    localparam logic [1:0] REG_SLOT_COUNT    = 2'd0;
    localparam logic [1:0] REG_VERTEX_CAP    = 2'd1;
    localparam logic [1:0] REG_INDEX_CAP     = 2'd2;
    localparam logic [1:0] REG_DEFAULT_ALIGN = 2'd3;

    // register reset values
    localparam logic [SCOUNT_W-1:0] RST_SLOT_COUNT    = 5'd2;
    localparam logic [OFF_W-1:0]    RST_VERTEX_CAP    = 25'd1048576;
    localparam logic [OFF_W-1:0]    RST_INDEX_CAP     = 25'd262144;
    localparam logic [ALIGN_W-1:0]  RST_DEFAULT_ALIGN = 13'd16;

    typedef struct packed {
        logic [SCOUNT_W-1:0] slot_count;
        logic [OFF_W-1:0]    vtx_pool_bytes;
        logic [OFF_W-1:0]    idx_pool_bytes;
        logic [ALIGN_W-1:0]  default_alignment;
    } t_cfg;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_rem_req;

endpackage

`default_nettype wire

// File: rtl/pfab_cfg.sv
// ----------------------------------------------------------------------------
// pfab_cfg: configuration register file
// APB-style write/read access to slot count, pool capacities and the
// default alignment.
// ----------------------------------------------------------------------------
`default_nettype none

module pfab_cfg import pfab_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slot_count        <= RST_SLOT_COUNT;
            r_cfg.vtx_pool_bytes    <= RST_VERTEX_CAP;
            r_cfg.idx_pool_bytes    <= RST_INDEX_CAP;
            r_cfg.default_alignment <= RST_DEFAULT_ALIGN;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_SLOT_COUNT:    r_cfg.slot_count        <= pwdata[SCOUNT_W-1:0];
                REG_VERTEX_CAP:    r_cfg.vtx_pool_bytes    <= pwdata[OFF_W-1:0];
                REG_INDEX_CAP:     r_cfg.idx_pool_bytes    <= pwdata[OFF_W-1:0];
                REG_DEFAULT_ALIGN: r_cfg.default_alignment <= pwdata[ALIGN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SLOT_COUNT:    prdata = CFG_DATA_W'(r_cfg.slot_count);
            REG_VERTEX_CAP:    prdata = CFG_DATA_W'(r_cfg.vtx_pool_bytes);
            REG_INDEX_CAP:     prdata = CFG_DATA_W'(r_cfg.idx_pool_bytes);
            REG_DEFAULT_ALIGN: prdata = CFG_DATA_W'(r_cfg.default_alignment);
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/pfab_rem.sv
// ----------------------------------------------------------------------------
// pfab_rem: shared bit-serial remainder unit
// Restoring division, one dividend bit per cycle, remainder only. Used for
// the slot modulo of begin frame and the alignment remainder of reserve.
// ----------------------------------------------------------------------------
`default_nettype none

module pfab_rem import pfab_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_rem_req             i_req,
    output logic                      o_done,
    output logic      [DIVISOR_W-1:0] o_rem
);

    logic                  r_busy;
    logic                  r_done;
    logic [REM_CNT_W-1:0]  r_cnt;
    logic [DIVIDEND_W-1:0] r_num;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;

    logic [DIVISOR_W:0]    shifted;
    logic                  ge;
    logic [DIVISOR_W:0]    n_rem_wide;

    always_comb begin
        shifted    = {r_rem, r_num[DIVIDEND_W-1]};
        ge         = shifted >= {1'b0, r_div};
        n_rem_wide = ge ? (shifted - {1'b0, r_div}) : shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                // remainder stays below the divisor, so the top bit is free
                r_rem <= n_rem_wide[DIVISOR_W-1:0];
                r_num <= {r_num[DIVIDEND_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == {REM_CNT_W{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("remainder unit restarted while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("remainder done without a running division");

endmodule

`default_nettype wire

// File: rtl/per_frame_aligned_bump_allocator.sv
// Sequence: begin frame and reserve with alignment above 1 run the serial
// remainder (32 serial remainder steps), then the align and check steps;
// flush, zero-size or unaligned reserve and unused mode go straight to align.
// One transaction at a time: a new item is taken only while the sequencer is idle.
// Reset (synchronous, active low) clears all slot offsets, flush marks, peaks,
// overflow counters and the current slot, and loads the register defaults.
// ----------------------------------------------------------------------------
// per_frame_aligned_bump_allocator: ring of per-frame vertex/index bump pools
// Sequencer around one shared remainder unit; handles begin frame, aligned
// reserve with overflow counting and peak tracking, and flush reporting.
// ----------------------------------------------------------------------------
`default_nettype none

module per_frame_aligned_bump_allocator import pfab_pkg::*; #(
    parameter int MAX_SLOTS   = 16,
    parameter int OFFSET_BITS = 25
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,

    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [MODE_W-1:0]     i_mode,
    input  wire logic                  i_pool,
    input  wire logic [OFF_W-1:0]      i_request_bytes,
    input  wire logic [ALIGN_W-1:0]    i_request_alignment,
    input  wire logic [FRAME_W-1:0]    i_frame_number,

    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [STATUS_W-1:0]   o_status,
    output logic      [SLOT_OUT_W-1:0] o_slot,
    output logic      [OFF_W-1:0]      o_granted_offset,
    output logic      [OFF_W-1:0]      o_granted_length,
    output logic      [OFF_W-1:0]      o_vertex_flush_start,
    output logic      [OFF_W-1:0]      o_vertex_flush_length,
    output logic      [OFF_W-1:0]      o_index_flush_start,
    output logic      [OFF_W-1:0]      o_index_flush_length,
    output logic      [OFF_W-1:0]      o_vertex_peak,
    output logic      [OFF_W-1:0]      o_index_peak,
    output logic      [COUNT_W-1:0]    o_vertex_overflow_count,
    output logic      [COUNT_W-1:0]    o_index_overflow_count
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int FILL_W = (OFFSET_BITS < OFF_W) ? OFFSET_BITS : OFF_W;
    localparam int ESL_W  = 7;
    localparam logic [ESL_W-1:0] MAX_SLOTS_V = ESL_W'(MAX_SLOTS);
    localparam logic [OFF_W-1:0] CAP_MAX = (OFFSET_BITS >= OFF_W) ? {OFF_W{1'b1}} :
                                           OFF_W'((64'd1 << OFFSET_BITS) - 64'd1);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_ALIGN, S_CHECK} t_state;

    t_cfg     cfg;
    t_rem_req rem_req;
    logic     rem_done;
    logic [DIVISOR_W-1:0] rem_val;

    pfab_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pfab_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_done  (rem_done),
        .o_rem   (rem_val)
    );

    // sequencer and item registers
    t_state               r_state;
    logic [MODE_W-1:0]    r_mode;
    logic                 r_pool;
    logic [OFF_W-1:0]     r_bytes;
    logic [ALIGN_W-1:0]   r_align;
    logic [OFF_W-1:0]     r_fill;
    logic [DIVISOR_W-1:0] r_rem_q;
    logic [OFF_W:0]       r_start;

    // allocator state
    logic [SLOT_W-1:0]    r_cur;
    logic [FILL_W-1:0]    r_vfill [MAX_SLOTS];
    logic [FILL_W-1:0]    r_ifill [MAX_SLOTS];
    logic [FILL_W-1:0]    r_vmark [MAX_SLOTS];
    logic [FILL_W-1:0]    r_imark [MAX_SLOTS];
    logic [OFF_W-1:0]     r_vpeak;
    logic [OFF_W-1:0]     r_ipeak;
    logic [COUNT_W-1:0]   r_vovf;
    logic [COUNT_W-1:0]   r_iovf;

    // result register
    logic                  r_o_valid;
    logic [STATUS_W-1:0]   r_o_status;
    logic [SLOT_OUT_W-1:0] r_o_slot;
    logic [OFF_W-1:0]      r_o_goff;
    logic [OFF_W-1:0]      r_o_glen;
    logic [OFF_W-1:0]      r_o_vfs;
    logic [OFF_W-1:0]      r_o_vfl;
    logic [OFF_W-1:0]      r_o_ifs;
    logic [OFF_W-1:0]      r_o_ifl;

    // accept side
    logic                 in_accept;
    logic [ESL_W-1:0]     eff_slots;
    logic [ALIGN_W-1:0]   a_sel;
    logic [OFF_W-1:0]     fill_in;
    logic                 needs_div;

    // check side
    logic                 out_free;
    logic                 commit;
    logic [OFF_W:0]       n_start;
    logic [OFF_W-1:0]     vcap_eff;
    logic [OFF_W-1:0]     icap_eff;
    logic [OFF_W:0]       cap26;
    logic                 over;
    logic [OFF_W:0]       end26;
    logic [FILL_W-1:0]    vfill_c;
    logic [FILL_W-1:0]    ifill_c;
    logic [FILL_W-1:0]    vmark_c;
    logic [FILL_W-1:0]    imark_c;
    logic [31:0]          slot_wide;

    logic [SLOT_W-1:0]     n_cur;
    logic [OFF_W-1:0]      n_vpeak;
    logic [OFF_W-1:0]      n_ipeak;
    logic [COUNT_W-1:0]    n_vovf;
    logic [COUNT_W-1:0]    n_iovf;
    logic [STATUS_W-1:0]   n_status;
    logic [OFF_W-1:0]      n_goff;
    logic [OFF_W-1:0]      n_glen;
    logic [OFF_W-1:0]      n_vfs;
    logic [OFF_W-1:0]      n_vfl;
    logic [OFF_W-1:0]      n_ifs;
    logic [OFF_W-1:0]      n_ifl;
    logic                  clear_slot;
    logic                  vfill_we;
    logic                  ifill_we;
    logic                  vmark_we;
    logic                  imark_we;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_o_valid || !i_out_stall;
    assign commit     = (r_state == S_CHECK) && out_free;

    always_comb begin
        if (cfg.slot_count == '0) begin
            eff_slots = ESL_W'(1);
        end else if (ESL_W'(cfg.slot_count) > MAX_SLOTS_V) begin
            eff_slots = MAX_SLOTS_V;
        end else begin
            eff_slots = ESL_W'(cfg.slot_count);
        end

        a_sel   = (i_request_alignment != '0) ? i_request_alignment : cfg.default_alignment;
        fill_in = i_pool ? OFF_W'(r_vfill[r_cur]) : OFF_W'(r_ifill[r_cur]);

        // alignment of 0 or 1 needs no rounding, remainder stays zero
        needs_div = (i_mode == MODE_BEGIN) ||
                    ((i_mode == MODE_RESERVE) && (i_request_bytes != '0) &&
                     (a_sel > ALIGN_W'(1)));

        rem_req.start    = in_accept && needs_div;
        rem_req.dividend = (i_mode == MODE_BEGIN) ? i_frame_number : DIVIDEND_W'(fill_in);
        rem_req.divisor  = (i_mode == MODE_BEGIN) ? DIVISOR_W'(eff_slots) : a_sel;
    end

    always_comb begin
        n_start = (r_rem_q != '0) ?
                  ({1'b0, r_fill} + (OFF_W+1)'(r_align - r_rem_q)) : {1'b0, r_fill};

        vcap_eff = (cfg.vtx_pool_bytes > CAP_MAX) ? CAP_MAX : cfg.vtx_pool_bytes;
        icap_eff = (cfg.idx_pool_bytes > CAP_MAX) ? CAP_MAX : cfg.idx_pool_bytes;
        cap26    = {1'b0, r_pool ? vcap_eff : icap_eff};
        over     = (r_start > cap26) || ({1'b0, r_bytes} > (cap26 - r_start));
        end26    = r_start + {1'b0, r_bytes};

        vfill_c = r_vfill[r_cur];
        ifill_c = r_ifill[r_cur];
        vmark_c = r_vmark[r_cur];
        imark_c = r_imark[r_cur];

        n_cur      = r_cur;
        n_vpeak    = r_vpeak;
        n_ipeak    = r_ipeak;
        n_vovf     = r_vovf;
        n_iovf     = r_iovf;
        n_status   = STATUS_OK;
        n_goff     = '0;
        n_glen     = '0;
        n_vfs      = '0;
        n_vfl      = '0;
        n_ifs      = '0;
        n_ifl      = '0;
        clear_slot = 1'b0;
        vfill_we   = 1'b0;
        ifill_we   = 1'b0;
        vmark_we   = 1'b0;
        imark_we   = 1'b0;

        case (r_mode)
            MODE_BEGIN: begin
                n_cur      = r_rem_q[SLOT_W-1:0];
                clear_slot = 1'b1;
            end
            MODE_RESERVE: begin
                if (r_bytes == '0) begin
                    n_status = STATUS_ZERO;
                end else if (over) begin
                    n_status = STATUS_OVERFLOW;
                    if (r_pool) begin
                        if (r_vovf != {COUNT_W{1'b1}}) n_vovf = r_vovf + 1'b1;
                    end else begin
                        if (r_iovf != {COUNT_W{1'b1}}) n_iovf = r_iovf + 1'b1;
                    end
                end else begin
                    n_goff = r_start[OFF_W-1:0];
                    n_glen = r_bytes;
                    if (r_pool) begin
                        vfill_we = 1'b1;
                        if (end26 > {1'b0, r_vpeak}) n_vpeak = end26[OFF_W-1:0];
                    end else begin
                        ifill_we = 1'b1;
                        if (end26 > {1'b0, r_ipeak}) n_ipeak = end26[OFF_W-1:0];
                    end
                end
            end
            MODE_FLUSH: begin
                n_vfs = OFF_W'(vmark_c);
                if (vfill_c > vmark_c) begin
                    n_vfl    = OFF_W'(vfill_c - vmark_c);
                    vmark_we = 1'b1;
                end
                n_ifs = OFF_W'(imark_c);
                if (ifill_c > imark_c) begin
                    n_ifl    = OFF_W'(ifill_c - imark_c);
                    imark_we = 1'b1;
                end
            end
            default: ;
        endcase

        slot_wide = 32'(n_cur);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_cur     <= '0;
            r_vpeak   <= '0;
            r_ipeak   <= '0;
            r_vovf    <= '0;
            r_iovf    <= '0;
            for (int k = 0; k < MAX_SLOTS; k++) begin
                r_vfill[k] <= '0;
                r_ifill[k] <= '0;
                r_vmark[k] <= '0;
                r_imark[k] <= '0;
            end
        end else begin
            if (commit) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_mode  <= i_mode;
                        r_pool  <= i_pool;
                        r_bytes <= i_request_bytes;
                        r_align <= a_sel;
                        r_fill  <= fill_in;
                        r_rem_q <= '0;
                        r_state <= needs_div ? S_DIV : S_ALIGN;
                    end
                end
                S_DIV: begin
                    if (rem_done) begin
                        r_rem_q <= rem_val;
                        r_state <= S_ALIGN;
                    end
                end
                S_ALIGN: begin
                    r_start <= n_start;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (out_free) begin
                        r_state    <= S_IDLE;
                        r_o_status <= n_status;
                        r_o_slot   <= slot_wide[SLOT_OUT_W-1:0];
                        r_o_goff   <= n_goff;
                        r_o_glen   <= n_glen;
                        r_o_vfs    <= n_vfs;
                        r_o_vfl    <= n_vfl;
                        r_o_ifs    <= n_ifs;
                        r_o_ifl    <= n_ifl;
                        r_cur      <= n_cur;
                        r_vpeak    <= n_vpeak;
                        r_ipeak    <= n_ipeak;
                        r_vovf     <= n_vovf;
                        r_iovf     <= n_iovf;
                        if (clear_slot) begin
                            r_vfill[n_cur] <= '0;
                            r_ifill[n_cur] <= '0;
                            r_vmark[n_cur] <= '0;
                            r_imark[n_cur] <= '0;
                        end
                        if (vfill_we) r_vfill[r_cur] <= end26[FILL_W-1:0];
                        if (ifill_we) r_ifill[r_cur] <= end26[FILL_W-1:0];
                        if (vmark_we) r_vmark[r_cur] <= vfill_c;
                        if (imark_we) r_imark[r_cur] <= ifill_c;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid             = r_o_valid;
    assign o_status                = r_o_status;
    assign o_slot                  = r_o_slot;
    assign o_granted_offset        = r_o_goff;
    assign o_granted_length        = r_o_glen;
    assign o_vertex_flush_start    = r_o_vfs;
    assign o_vertex_flush_length   = r_o_vfl;
    assign o_index_flush_start     = r_o_ifs;
    assign o_index_flush_length    = r_o_ifl;
    assign o_vertex_peak           = r_vpeak;
    assign o_index_peak            = r_ipeak;
    assign o_vertex_overflow_count = r_vovf;
    assign o_index_overflow_count  = r_iovf;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE))
        else $error("sequencer idle right after a transaction was taken");

    a_rem_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_done |-> (r_state == S_DIV))
        else $error("remainder result arrived outside the divide step");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur) < 32'(MAX_SLOTS))
        else $error("current slot beyond slot storage");

endmodule

`default_nettype wire
